FILE: design/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared property wrappers with clocking and reset disable built in.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check a property at every rising edge outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned STAT_W   = 2;

  // Request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [STAT_W-1:0]        status_t;

  // Controller to datapath command
  typedef struct packed {
    logic    insert;
    logic    remove;
    logic    load;
    status_t status;
    count_t  count_cur;
    count_t  count_next;
  } spq_cmd_t;

endpackage

FILE: design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Request and result channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  data_t value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  data_t   removed_value;
  status_t status;
  logic    now_empty;
  count_t  entry_count;

  modport source (output valid, removed_value, status, now_empty, entry_count, input ready);
  modport sink   (input valid, removed_value, status, now_empty, entry_count, output ready);
endinterface

FILE: design/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded ascending priority queue of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per handshake: command 0 inserts value in sorted
//   position (ahead of equal values), command 1 removes the minimum.
//   out_o returns exactly one result per request, in request order: the
//   removed value (zero unless a remove succeeded), a status (ok, remove
//   from empty, insert into full dropped), the empty flag and the count.
//   A request accepted at one edge has its result registered and valid
//   after that edge. Throughput is one request per cycle while each result
//   is taken, set by the update of the row of compare cells with the entries.
//   A result register separates the two channels; while the receiver stalls
//   the result holds and in_i.ready stays low, and a request is taken in the
//   same cycle the held result is taken.
//   Reset empties the queue and drops any pending result; entry contents are
//   not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Control: acceptance, count and status
  spq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  // Datapath: sorted entries and result register
  spq_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .value_i         (in_i.value),
    .removed_value_o (out_o.removed_value),
    .status_o        (out_o.status),
    .now_empty_o     (out_o.now_empty),
    .entry_count_o   (out_o.entry_count)
  );

endmodule

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Request acceptance, fill count, status decode and result register control.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_command_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic   state_q, state_d;
  count_t count_q, count_d;
  logic   accept;
  logic   full;
  logic   empty;

  // Take a request whenever the result register is free or being drained
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_HOLD);
  assign full        = (count_q == CNT_W'(CAPACITY));
  assign empty       = (count_q == '0);

  // Decode the request into a datapath command
  always_comb begin
    count_d          = count_q;
    cmd_o            = '0;
    cmd_o.count_cur  = count_q;
    if (accept) begin
      cmd_o.load = 1'b1;
      if (in_command_i == CMD_INSERT) begin
        if (full) begin
          cmd_o.status = STATUS_FULL;
        end else begin
          cmd_o.insert = 1'b1;
          count_d      = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          cmd_o.status = STATUS_EMPTY;
        end else begin
          cmd_o.remove = 1'b1;
          count_d      = count_q - CNT_W'(1);
        end
      end
    end
    cmd_o.count_next = count_d;
  end

  // Track result register occupancy
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !accept) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NEVER(a_ins_rem, clk_i, rst_ni, cmd_o.insert && cmd_o.remove, "insert and remove")
  `SPQ_ASSERT(a_ins_count, clk_i, rst_ni, cmd_o.insert |=> count_q == $past(count_q) + CNT_W'(1), "insert count")
  `SPQ_ASSERT(a_load_hold, clk_i, rst_ni, cmd_o.load |=> out_valid_o, "result lost")

endmodule

FILE: design/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Sorted entry array of compare cells and the result register.
// ----------------------------------------------------------------------------
module spq_dp (
  input  logic              clk_i,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  spq_pkg::data_t    value_i,
  output spq_pkg::data_t    removed_value_o,
  output spq_pkg::status_t  status_o,
  output logic              now_empty_o,
  output spq_pkg::count_t   entry_count_o
);
  import spq_pkg::*;

  data_t   entries_q [CAPACITY];
  data_t   entries_d [CAPACITY];
  logic    take      [CAPACITY];
  data_t   rv_q;
  status_t status_q;
  logic    empty_q;
  count_t  count_q;

  // One compare cell per entry; the new value lands at the first taking cell
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign take[i] = (CNT_W'(i) >= cmd_i.count_cur) || (entries_q[i] >= value_i);

    always_comb begin
      entries_d[i] = entries_q[i];
      if (cmd_i.insert && take[i]) begin
        if (i == 0) begin
          entries_d[i] = value_i;
        end else begin
          entries_d[i] = take[(i > 0) ? i - 1 : 0] ? entries_q[(i > 0) ? i - 1 : 0] : value_i;
        end
      end else if (cmd_i.remove) begin
        if (i < CAPACITY - 1) begin
          entries_d[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    // Shift or hold the entry
    always_ff @(posedge clk_i) begin
      if (cmd_i.insert || cmd_i.remove) entries_q[i] <= entries_d[i];
    end
  end

  // Capture the result of the step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rv_q     <= cmd_i.remove ? entries_q[0] : '0;
      status_q <= cmd_i.status;
      empty_q  <= (cmd_i.count_next == '0);
      count_q  <= cmd_i.count_next;
    end
  end

  assign removed_value_o = rv_q;
  assign status_o        = status_q;
  assign now_empty_o     = empty_q;
  assign entry_count_o   = count_q;

endmodule

FILE: verif/spq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the request and result channels of the sorted priority queue,
// keeps its own sorted copy of the stored values and compares each result
// with the one predicted for the oldest request still outstanding.
// ----------------------------------------------------------------------------
module spq_order_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  logic             req_command_i,
  input  spq_pkg::data_t   req_value_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  spq_pkg::data_t   res_removed_value_i,
  input  spq_pkg::status_t res_status_i,
  input  logic             res_now_empty_i,
  input  spq_pkg::count_t  res_entry_count_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    data_t   removed_value;
    status_t status;
    logic    now_empty;
    count_t  entry_count;
  } queue_result_t;

  // Shadow copy of the queue contents, ascending from index zero
  data_t         shadow_entries [CAPACITY];
  int unsigned   shadow_count;
  queue_result_t expected_results [$];
  int unsigned   fail_count;
  int unsigned   results_seen;

  // Apply one request to the shadow queue and return the result it causes
  function automatic queue_result_t apply_request(logic command, data_t value);
    queue_result_t res;
    int unsigned   pos;
    res = '0;
    if (command == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        // New value goes ahead of any equal values already stored
        pos = 0;
        while (pos < shadow_count && shadow_entries[pos] < value) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_entries[i] = shadow_entries[i-1];
        end
        shadow_entries[pos] = value;
        shadow_count++;
        res.status = STATUS_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed_value = shadow_entries[0];
        for (int unsigned i = 1; i < shadow_count; i++) begin
          shadow_entries[i-1] = shadow_entries[i];
        end
        shadow_count--;
        res.status = STATUS_OK;
      end
    end
    res.now_empty   = (shadow_count == 0);
    res.entry_count = count_t'(shadow_count);
    return res;
  endfunction

  // Count a failure; only the first few are printed
  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Compare results first, then predict the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      shadow_count = 0;
      fail_count   = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.removed_value = res_removed_value_i;
        got.status        = res_status_i;
        got.now_empty     = res_now_empty_i;
        got.entry_count   = res_entry_count_i;
        if (expected_results.size() == 0) begin
          log_failure($sformatf({"result %0d with no request outstanding: removed=%0d ",
                                 "status=%0d empty=%0b count=%0d"},
                                results_seen, got.removed_value, got.status,
                                got.now_empty, got.entry_count));
        end else begin
          want = expected_results.pop_front();
          if (got.removed_value !== want.removed_value || got.status !== want.status ||
              got.now_empty !== want.now_empty || got.entry_count !== want.entry_count) begin
            log_failure($sformatf({"result %0d mismatch: expected removed=%0d status=%0d ",
                                   "empty=%0b count=%0d, got removed=%0d status=%0d ",
                                   "empty=%0b count=%0d"},
                                  results_seen, want.removed_value, want.status,
                                  want.now_empty, want.entry_count, got.removed_value,
                                  got.status, got.now_empty, got.entry_count));
          end
        end
        results_seen++;
      end
      if (req_valid_i && req_ready_i) begin
        expected_results.push_back(apply_request(req_command_i, req_value_i));
      end
      fail_count_o <= fail_count;
      pending_o    <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Drives insert and remove-minimum requests into the queue with random gaps
// and result stalls, first a directed fill-and-drain pass through the corner
// cases, then phases of random traffic that swing the queue between empty
// and full. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam data_t MIN_VALUE = 32'sh8000_0000;
  localparam data_t MAX_VALUE = 32'sh7fff_ffff;

  logic        clk_i;
  logic        rst_ni;
  logic        steady_phase;
  int unsigned fail_count;
  int unsigned pending_count;

  spq_in_if  req_ch ();
  spq_out_if res_ch ();

  sorted_priority_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  spq_order_checker checker_inst (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (req_ch.valid),
    .req_ready_i         (req_ch.ready),
    .req_command_i       (req_ch.command),
    .req_value_i         (req_ch.value),
    .res_valid_i         (res_ch.valid),
    .res_ready_i         (res_ch.ready),
    .res_removed_value_i (res_ch.removed_value),
    .res_status_i        (res_ch.status),
    .res_now_empty_i     (res_ch.now_empty),
    .res_entry_count_i   (res_ch.entry_count),
    .fail_count_o        (fail_count),
    .pending_o           (pending_count)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Send one request after a random gap and hold it until taken
  task automatic send_request(logic command, data_t value);
    int unsigned gap;
    gap = steady_phase ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= command;
    req_ch.value   <= value;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
  endtask

  // Draw a value biased toward duplicates and the extremes
  function automatic data_t pick_value();
    case ($urandom_range(0, 3))
      0:       return data_t'($signed($urandom_range(0, 16)) - 8);
      1: begin
        case ($urandom_range(0, 3))
          0:       return MIN_VALUE;
          1:       return MAX_VALUE;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // Result side: stall ready at random, then take one result
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = steady_phase ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        res_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Request side: directed corner cases, then random phases
  initial begin
    int unsigned insert_pct;
    logic        command;
    data_t       directed_fill [16];
    directed_fill = '{MAX_VALUE, MIN_VALUE, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, -32'sd5,
                      MIN_VALUE, MAX_VALUE, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100,
                      -32'sd100, 32'sd3, 32'sd3};
    steady_phase   = 1'b0;
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_INSERT;
    req_ch.value   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Remove from empty, fill with extremes and equal values, overfill, drain part
    send_request(CMD_REMOVE, data_t'($urandom));
    foreach (directed_fill[i]) send_request(CMD_INSERT, directed_fill[i]);
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, MIN_VALUE);
    repeat (6) send_request(CMD_REMOVE, data_t'($urandom));

    // Random phases with insert bias chosen so the queue swings empty to full
    for (int phase = 0; phase < 21; phase++) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        default: insert_pct = 75;
      endcase
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        command = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        send_request(command, command == CMD_INSERT ? pick_value() : data_t'($urandom));
      end
    end
    req_ch.valid <= 1'b0;
    steady_phase = 1'b0;

    // Drain outstanding results, then allow for late extras
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_priority_queue_core verification clean");
    end else begin
      $display("sorted_priority_queue_core verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #1_000_000;
    $display("sorted_priority_queue_core verification failed");
    $finish;
  end

endmodule
